@@ rtl/core/sorted_multiset_floor_take_unit_macros.svh @@
// Assertion helpers shared by the RTL of the sorted multiset unit.
// Both macros expect a clock named clk and an active-low reset named rst_n.
`ifndef SORTED_MULTISET_FLOOR_TAKE_UNIT_MACROS_SVH
`define SORTED_MULTISET_FLOOR_TAKE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SMFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/smft_pkg.sv @@
package smft_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int KEY_BITS_DEFAULT = 30;

    // Width of the key_out field on the result word.
    localparam int OUT_KEY_BITS = 30;

    // Binary levels of the extraction tree between two register ranks.
    localparam int TREE_STAGE_LEVELS = 4;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_TAKE   = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_TAKEN    = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_DRAIN,
        FSM_HOLD
    } fsm_t;

    typedef struct packed {
        logic do_insert;
        logic do_take;
    } cell_ctl_t;

endpackage

@@ rtl/core/smft_cell.sv @@
module smft_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = smft_pkg::KEY_BITS_DEFAULT,
    parameter int CNT_W    = 9
) (
    input  logic                  clk,
    input  smft_pkg::cell_ctl_t   ctl,
    input  logic [KEY_BITS-1:0]   value,
    input  logic [CNT_W-1:0]      count,
    input  logic                  le_left,
    input  logic [KEY_BITS-1:0]   key_left,
    input  logic                  le_right,
    input  logic [KEY_BITS-1:0]   key_right,
    output logic                  le,
    output logic [KEY_BITS-1:0]   key,
    output logic [KEY_BITS-1:0]   pick_key
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                occupied;
    logic                pick;

    assign occupied = count > CNT_W'(INDEX);
    assign le       = occupied && (key_reg <= value);
    assign key      = key_reg;

    // The cell holding the last key not above the limit gives it up on a take.
    assign pick     = ctl.do_take && le && !le_right;
    assign pick_key = pick ? key_reg : '0;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.do_insert && !le)
        begin
            // The first cell above the limit takes the new key, the rest shift up.
            key_next = le_left ? value : key_left;
        end
        else if (ctl.do_take && !le_right)
        begin
            key_next = key_right;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

@@ rtl/core/smft_or_tree.sv @@
module smft_or_tree #(
    parameter int LEAVES = smft_pkg::CAPACITY_DEFAULT,
    parameter int WIDTH  = smft_pkg::KEY_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] leaf [LEAVES],
    output logic [WIDTH-1:0] root
);

    localparam int DEPTH = $clog2(LEAVES);
    localparam int SPAN  = 1 << DEPTH;
    localparam int NODES = 2 * SPAN - 1;

    // Heap layout: node n has children 2n+1 and 2n+2, leaves sit at the end.
    logic [WIDTH-1:0] node [NODES];

    genvar n;
    genvar j;

    generate
        for (n = 0; n < SPAN - 1; n++)
        begin : g_node
            localparam int LVL = $clog2(n + 2) - 1;
            if (LVL % smft_pkg::TREE_STAGE_LEVELS == 0)
            begin : g_reg
                logic [WIDTH-1:0] sum_reg;
                always_ff @(posedge clk)
                begin
                    sum_reg <= node[2*n+1] | node[2*n+2];
                end
                assign node[n] = sum_reg;
            end
            else
            begin : g_comb
                assign node[n] = node[2*n+1] | node[2*n+2];
            end
        end

        for (j = 0; j < SPAN; j++)
        begin : g_leaf
            if (j < LEAVES)
            begin : g_used
                assign node[SPAN-1+j] = leaf[j];
            end
            else
            begin : g_pad
                assign node[SPAN-1+j] = '0;
            end
        end
    endgenerate

    assign root = node[0];

endmodule

@@ rtl/core/sorted_multiset_floor_take_unit.sv @@
// Sorted multiset with floor-take. Keys are kept in ascending order in a row
// of cells, one key per cell, and duplicates are allowed.
// Request channel (req_valid, req_stall, action, value): action 0 inserts
// value, action 1 removes and returns the largest stored key not above value.
// Response channel (rsp_valid, rsp_stall, status, key_out): one word per
// request, in request order. key_out carries the removed key, else zero.
// Every cell compares its key with the request in the execute cycle, and the
// cells from the insertion or removal point onward shift by one place in that
// same cycle. The removed key then climbs an OR tree with a register rank every
// four levels before the response word is presented. One request is in flight
// at a time and the request channel reopens in the same cycle as the word is
// presented, so a new request is only taken once the last word is presented.
// req_stall is high while a request is in flight.
// If rsp_stall holds a finished word, the next result waits in a holding
// register, and requests stop until that word has been taken.
// Reset empties the table at once; no clearing pass is needed.
module sorted_multiset_floor_take_unit #(
    parameter int CAPACITY = smft_pkg::CAPACITY_DEFAULT,
    parameter int KEY_BITS = smft_pkg::KEY_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic                             action,
    input  logic [KEY_BITS-1:0]              value,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic [smft_pkg::OUT_KEY_BITS-1:0] key_out
);

    `include "sorted_multiset_floor_take_unit_macros.svh"

    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int TREE_DEPTH = $clog2(CAPACITY);
    localparam int TREE_LAT   = (TREE_DEPTH + smft_pkg::TREE_STAGE_LEVELS - 1)
                                / smft_pkg::TREE_STAGE_LEVELS;
    localparam int DRAIN_W    = $clog2(TREE_LAT + 1);
    localparam int OUT_W      = smft_pkg::OUT_KEY_BITS;

    smft_pkg::fsm_t      state_reg;
    smft_pkg::fsm_t      state_next;
    smft_pkg::action_t   action_reg;
    smft_pkg::action_t   action_next;
    logic [KEY_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0] value_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [DRAIN_W-1:0]  drain_cnt_reg;
    logic [DRAIN_W-1:0]  drain_cnt_next;
    smft_pkg::status_t   status_pend_reg;
    smft_pkg::status_t   status_pend_next;
    logic [OUT_W-1:0]    key_pend_reg;
    logic [OUT_W-1:0]    key_pend_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    smft_pkg::status_t   status_reg;
    smft_pkg::status_t   status_next;
    logic [OUT_W-1:0]    key_out_reg;
    logic [OUT_W-1:0]    key_out_next;

    smft_pkg::cell_ctl_t ctl;
    logic                full;
    logic                found;
    logic                rsp_free;
    logic                req_accept;
    logic                tree_done;
    logic [KEY_BITS-1:0] root;
    logic [OUT_W-1:0]    root_out;

    logic                cell_le   [CAPACITY];
    logic [KEY_BITS-1:0] cell_key  [CAPACITY];
    logic [KEY_BITS-1:0] cell_pick [CAPACITY];

    assign full       = count_reg == CNT_W'(CAPACITY);
    assign found      = cell_le[0];
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign req_accept = req_valid && !req_stall;
    assign tree_done  = drain_cnt_reg == '0;
    assign root_out   = OUT_W'(root);

    assign ctl.do_insert = (state_reg == smft_pkg::FSM_EXEC)
                           && (action_reg == smft_pkg::ACT_INSERT) && !full;
    assign ctl.do_take   = (state_reg == smft_pkg::FSM_EXEC)
                           && (action_reg == smft_pkg::ACT_TAKE) && found;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                le_left;
            logic [KEY_BITS-1:0] key_left;
            logic                le_right;
            logic [KEY_BITS-1:0] key_right;

            if (i == 0)
            begin : g_first
                assign le_left  = 1'b1;
                assign key_left = '0;
            end
            else
            begin : g_inner_l
                assign le_left  = cell_le[i-1];
                assign key_left = cell_key[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign le_right  = 1'b0;
                assign key_right = '0;
            end
            else
            begin : g_inner_r
                assign le_right  = cell_le[i+1];
                assign key_right = cell_key[i+1];
            end

            smft_cell #(
                .INDEX    (i),
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .value     (value_reg),
                .count     (count_reg),
                .le_left   (le_left),
                .key_left  (key_left),
                .le_right  (le_right),
                .key_right (key_right),
                .le        (cell_le[i]),
                .key       (cell_key[i]),
                .pick_key  (cell_pick[i])
            );
        end
    endgenerate

    smft_or_tree #(
        .LEAVES (CAPACITY),
        .WIDTH  (KEY_BITS)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_pick),
        .root (root)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smft_pkg::FSM_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = smft_pkg::FSM_EXEC;
                end
            end
            smft_pkg::FSM_EXEC:
            begin
                state_next = smft_pkg::FSM_DRAIN;
            end
            smft_pkg::FSM_DRAIN:
            begin
                if (tree_done)
                begin
                    state_next = rsp_free ? smft_pkg::FSM_IDLE : smft_pkg::FSM_HOLD;
                end
            end
            smft_pkg::FSM_HOLD:
            begin
                if (rsp_free)
                begin
                    state_next = smft_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = smft_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        req_stall        = state_reg != smft_pkg::FSM_IDLE;
        action_next      = action_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        drain_cnt_next   = drain_cnt_reg;
        status_pend_next = status_pend_reg;
        key_pend_next    = key_pend_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        status_next      = status_reg;
        key_out_next     = key_out_reg;

        case (state_reg)
            smft_pkg::FSM_IDLE:
            begin
                if (req_valid)
                begin
                    action_next = smft_pkg::action_t'(action);
                    value_next  = value;
                end
            end
            smft_pkg::FSM_EXEC:
            begin
                drain_cnt_next = DRAIN_W'(TREE_LAT - 1);
                if (action_reg == smft_pkg::ACT_INSERT)
                begin
                    status_pend_next = full ? smft_pkg::ST_FULL : smft_pkg::ST_INSERTED;
                    if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    status_pend_next = found ? smft_pkg::ST_TAKEN : smft_pkg::ST_NONE;
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            smft_pkg::FSM_DRAIN:
            begin
                if (!tree_done)
                begin
                    drain_cnt_next = drain_cnt_reg - 1'b1;
                end
                else if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = status_pend_reg;
                    key_out_next   = root_out;
                end
                else
                begin
                    // The tree flushes after this cycle, so park the key.
                    key_pend_next = root_out;
                end
            end
            smft_pkg::FSM_HOLD:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = status_pend_reg;
                    key_out_next   = key_pend_reg;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smft_pkg::FSM_IDLE;
            count_reg     <= '0;
            drain_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drain_cnt_reg <= drain_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        value_reg       <= value_next;
        status_pend_reg <= status_pend_next;
        key_pend_reg    <= key_pend_next;
        status_reg      <= status_next;
        key_out_reg     <= key_out_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign key_out   = key_out_reg;

    `SMFT_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(CAPACITY),
        "entry count exceeds capacity")
    `SMFT_ASSERT_NEXT(a_one_in_flight, req_accept, req_stall,
        "request channel open right after an accepted word")
    `SMFT_ASSERT_NOW(a_key_only_on_take, rsp_valid && (status != smft_pkg::ST_TAKEN),
        key_out == '0, "nonzero key on a response that removed nothing")
    `SMFT_ASSERT_NOW(a_count_moves_in_exec, count_reg != $past(count_reg),
        $past(state_reg) == smft_pkg::FSM_EXEC, "entry count changed outside execute")

endmodule
